// ===== hdl/soa_pkg.sv =====
// Shared types, sizes and codes for the slab object allocator.
// No dependencies; the interfaces and the top level refer to this package by scoped name.
package soa_pkg;

  localparam int NUM_SLABS  = 64;
  localparam int PAGE_BYTES = 4096;
  localparam int MAX_SLOTS  = 512;

  // field widths of the channels
  localparam int OP_W   = 1;
  localparam int SID_W  = 6;
  localparam int OFF_W  = 12;
  localparam int STAT_W = 2;
  localparam int SZ_W   = 13;
  localparam int CNT_W  = 10;

  localparam int SLAB_W = (NUM_SLABS > 1) ? $clog2(NUM_SLABS) : 1;
  localparam int LINK_W = $clog2(NUM_SLABS + 1);
  localparam int SLOT_W = $clog2(MAX_SLOTS + 1);
  localparam int PAGE_W = $clog2(PAGE_BYTES + 1);
  localparam int DIV_W  = (PAGE_W > SZ_W) ? PAGE_W : SZ_W;
  localparam int DCNT_W = $clog2(DIV_W + 1);

  // slot bitmap: 32-bit words, a fixed block of words per slab
  localparam int BM_W   = 32;
  localparam int BIT_W  = 5;
  localparam int WPS    = (MAX_SLOTS + BM_W - 1) / BM_W;
  localparam int WORD_W = (WPS > 1) ? $clog2(WPS) : 1;
  localparam int KW     = WORD_W + BIT_W;
  localparam int BM_AW  = SLAB_W + WORD_W;

  // free-slab search, eight pool entries a cycle
  localparam int NCH  = (NUM_SLABS + 7) / 8;
  localparam int CH_W = (NCH > 1) ? $clog2(NCH) : 1;

  localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(NUM_SLABS);
  localparam logic [SZ_W-1:0]   MIN_OBJ  = SZ_W'(8);
  localparam logic [SZ_W-1:0]   OBJ_RST  = SZ_W'(64);

  localparam logic [OP_W-1:0] OP_ALLOC = 1'b0;
  localparam logic [OP_W-1:0] OP_FREE  = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_NO_SLAB  = 2'd1;
  localparam logic [STAT_W-1:0] ST_BAD_FREE = 2'd2;

  localparam int APB_AW = 3;
  localparam logic REG_OBJ_SIZE = 1'b0;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV,
    S_DIVD,
    S_WRD,
    S_WCHK,
    S_MUL,
    S_FINDF,
    S_INIT,
    S_LINK,
    S_FRD,
    S_FCHK,
    S_UNL,
    S_DONE
  } soa_state_e;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [SID_W-1:0]  out_slab;
    logic [OFF_W-1:0]  out_offset;
    logic              slab_released;
  } soa_rsp_t;

endpackage

// ===== hdl/soa_if.sv =====
// Request and response channel interfaces of the slab object allocator.
// Depends on soa_pkg for field widths.
interface soa_req_if;
  logic                       valid;
  logic                       ready;
  logic [soa_pkg::OP_W-1:0]   op;
  logic [soa_pkg::SID_W-1:0]  slab_id;
  logic [soa_pkg::OFF_W-1:0]  byte_offset;
  modport source (output valid, output op, output slab_id, output byte_offset, input ready);
  modport sink   (input valid, input op, input slab_id, input byte_offset, output ready);
endinterface

interface soa_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [soa_pkg::STAT_W-1:0]  status;
  logic [soa_pkg::SID_W-1:0]   out_slab;
  logic [soa_pkg::OFF_W-1:0]   out_offset;
  logic                        slab_released;
  modport source (output valid, output status, output out_slab, output out_offset,
                  output slab_released, input ready);
  modport sink   (input valid, input status, input out_slab, input out_offset,
                  input slab_released, output ready);
endinterface

// ===== hdl/soa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module soa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== hdl/slab_object_allocator.sv =====
// Slab object allocator top level: sequencer, shared divider, APB register.
// Depends on soa_pkg, soa_req_if / soa_rsp_if and soa_ram.
//
//  channel  | dir | handshake           | beat
//  req_i    | in  | valid/ready         | op, slab_id, byte_offset
//  rsp_o    | out | valid/ready         | status, out_slab, out_offset, slab_released
//  apb      | in  | psel/penable, pready| object_size at byte address 0
//
// One request at a time; req_i.ready is high only while the sequencer is idle.
// Both ops start with a restoring division (page / size or offset / size).
// Free then ends at once when rejected up front, else reads and clears the slot bit, and unlinks on release.
// Allocate reads and checks each bitmap word it scans along the slab list, plus a pool
// search and a bitmap clear when a new slab is linked. A finished beat waits in an output
// register; reset clears control state only, slab storage is set up on activation.
module slab_object_allocator (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  soa_req_if.sink                        req_i,
  soa_rsp_if.source                      rsp_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [soa_pkg::APB_AW-1:0]     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  function automatic logic [soa_pkg::BIT_W-1:0] first_one(input logic [31:0] v);
    logic [soa_pkg::BIT_W-1:0] r;
    r = '0;
    for (int i = 31; i >= 0; i--) begin
      if (v[i]) r = soa_pkg::BIT_W'(i);
    end
    return r;
  endfunction

  soa_pkg::soa_state_e state_q, state_d;

  logic [soa_pkg::SZ_W-1:0]   obj_size_q;
  logic [soa_pkg::OP_W-1:0]   op_q;
  logic [soa_pkg::SID_W-1:0]  sid_q;
  logic [soa_pkg::OFF_W-1:0]  off_q;
  logic [soa_pkg::SZ_W-1:0]   sz_q;
  logic [soa_pkg::DIV_W-1:0]  quo_q;
  logic [soa_pkg::DIV_W:0]    rem_q;
  logic [soa_pkg::DCNT_W-1:0] dcnt_q;
  logic [soa_pkg::SLOT_W-1:0] n_q;
  logic [soa_pkg::LINK_W-1:0] cur_q;
  logic [soa_pkg::WORD_W-1:0] word_q;
  logic [soa_pkg::KW-1:0]     slot_q;
  logic [soa_pkg::LINK_W-1:0] p_q, q_q;
  logic [soa_pkg::CH_W-1:0]   chunk_q;
  logic [soa_pkg::SLAB_W-1:0] new_q;
  logic [soa_pkg::LINK_W-1:0] head_q, tail_q;
  logic [soa_pkg::NUM_SLABS-1:0] act_q;
  soa_pkg::soa_rsp_t          res_q, out_q;
  logic                       ov_q;

  // RAM ports
  logic                        bm_we;
  logic [soa_pkg::BM_AW-1:0]   bm_waddr, bm_raddr;
  logic [soa_pkg::BM_W-1:0]    bm_wdata, bm_rdata;
  logic                        cnt_we;
  logic [soa_pkg::SLAB_W-1:0]  cnt_waddr, cnt_raddr;
  logic [soa_pkg::CNT_W-1:0]   cnt_wdata, cnt_rdata;
  logic                        nx_we;
  logic [soa_pkg::SLAB_W-1:0]  nx_waddr, nx_raddr;
  logic [soa_pkg::LINK_W-1:0]  nx_wdata, nx_rdata;
  logic                        pv_we;
  logic [soa_pkg::SLAB_W-1:0]  pv_waddr, pv_raddr;
  logic [soa_pkg::LINK_W-1:0]  pv_wdata, pv_rdata;

  soa_ram #(.WIDTH(soa_pkg::BM_W), .DEPTH(1 << soa_pkg::BM_AW)) u_bitmap (
    .clk_i, .we_i(bm_we), .waddr_i(bm_waddr), .wdata_i(bm_wdata),
    .raddr_i(bm_raddr), .rdata_o(bm_rdata));
  soa_ram #(.WIDTH(soa_pkg::CNT_W), .DEPTH(1 << soa_pkg::SLAB_W)) u_count (
    .clk_i, .we_i(cnt_we), .waddr_i(cnt_waddr), .wdata_i(cnt_wdata),
    .raddr_i(cnt_raddr), .rdata_o(cnt_rdata));
  soa_ram #(.WIDTH(soa_pkg::LINK_W), .DEPTH(1 << soa_pkg::SLAB_W)) u_next (
    .clk_i, .we_i(nx_we), .waddr_i(nx_waddr), .wdata_i(nx_wdata),
    .raddr_i(nx_raddr), .rdata_o(nx_rdata));
  soa_ram #(.WIDTH(soa_pkg::LINK_W), .DEPTH(1 << soa_pkg::SLAB_W)) u_prev (
    .clk_i, .we_i(pv_we), .waddr_i(pv_waddr), .wdata_i(pv_wdata),
    .raddr_i(pv_raddr), .rdata_o(pv_rdata));

  // ---- handshakes and APB ----
  logic req_acc, out_free;
  assign req_i.ready = (state_q == soa_pkg::S_IDLE);
  assign req_acc     = req_i.valid && req_i.ready;
  assign out_free    = !ov_q || rsp_o.ready;

  assign rsp_o.valid         = ov_q;
  assign rsp_o.status        = out_q.status;
  assign rsp_o.out_slab      = out_q.out_slab;
  assign rsp_o.out_offset    = out_q.out_offset;
  assign rsp_o.slab_released = out_q.slab_released;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == soa_pkg::REG_OBJ_SIZE) ? 32'(obj_size_q) : 32'd0;

  // ---- datapath helpers ----
  logic [soa_pkg::SZ_W-1:0]   eff_sz;
  logic [soa_pkg::DIV_W:0]    rem_sh;
  logic                       div_ge;
  logic [soa_pkg::SLOT_W-1:0] n_w;
  logic                       free_pre_ok;
  logic [soa_pkg::BM_W-1:0]   slot_mask, free_bits;
  logic [soa_pkg::BIT_W-1:0]  free_bit;
  logic                       word_last;
  logic [8*soa_pkg::NCH-1:0]  act_pad;
  logic [7:0]                 chunk_bits;
  logic [soa_pkg::BIT_W-1:0]  chunk_first;
  logic [2:0]                 chunk_low;
  logic [soa_pkg::SLAB_W-1:0] find_slab;
  logic [soa_pkg::BIT_W-1:0]  fbit;
  logic                       fbit_set;
  logic [soa_pkg::CNT_W-1:0]  cnt_dec;
  logic [soa_pkg::SLAB_W-1:0] cur_s, sid_s;

  assign cur_s = cur_q[soa_pkg::SLAB_W-1:0];
  assign sid_s = soa_pkg::SLAB_W'(sid_q);

  always_comb begin
    eff_sz = obj_size_q;
    if (obj_size_q < soa_pkg::MIN_OBJ) eff_sz = soa_pkg::MIN_OBJ;
    if (32'(obj_size_q) > soa_pkg::PAGE_BYTES) eff_sz = soa_pkg::SZ_W'(soa_pkg::PAGE_BYTES);
  end

  assign rem_sh = {rem_q[soa_pkg::DIV_W-1:0], quo_q[soa_pkg::DIV_W-1]};
  assign div_ge = rem_sh >= (soa_pkg::DIV_W + 1)'(sz_q);
  assign n_w    = (32'(quo_q) > soa_pkg::MAX_SLOTS) ? soa_pkg::SLOT_W'(soa_pkg::MAX_SLOTS)
                                                    : soa_pkg::SLOT_W'(quo_q);

  // slot k = off / size is in range when (k+1) * size fits the page
  assign free_pre_ok = (32'(sid_q) < soa_pkg::NUM_SLABS) && act_q[sid_s] &&
                       (rem_q == '0) &&
                       (32'(off_q) + 32'(sz_q) <= soa_pkg::PAGE_BYTES) &&
                       (32'(quo_q) < soa_pkg::MAX_SLOTS);

  always_comb begin
    for (int b = 0; b < soa_pkg::BM_W; b++) begin
      slot_mask[b] = (32'(word_q) * soa_pkg::BM_W + b) < 32'(n_q);
    end
  end
  assign free_bits = ~bm_rdata & slot_mask;
  assign free_bit  = first_one(free_bits);
  assign word_last = (32'(word_q) + 1) * soa_pkg::BM_W >= 32'(n_q);

  always_comb begin
    for (int i = 0; i < 8 * soa_pkg::NCH; i++) begin
      if (i < soa_pkg::NUM_SLABS) act_pad[i] = act_q[i];
      else                        act_pad[i] = 1'b1;
    end
  end
  assign chunk_bits  = act_pad[32'(chunk_q) * 8 +: 8];
  assign chunk_first = first_one(32'(~chunk_bits));
  assign chunk_low   = chunk_first[2:0];
  assign find_slab   = soa_pkg::SLAB_W'(32'(chunk_q) * 8 + 32'(chunk_low));

  assign fbit     = slot_q[soa_pkg::BIT_W-1:0];
  assign fbit_set = bm_rdata[fbit];
  assign cnt_dec  = (cnt_rdata != '0) ? cnt_rdata - 1'b1 : '0;

  // ---- next state ----
  always_comb begin
    state_d = state_q;
    case (state_q)
      soa_pkg::S_IDLE:  if (req_acc) state_d = soa_pkg::S_DIV;
      soa_pkg::S_DIV:   if (dcnt_q == soa_pkg::DCNT_W'(1)) state_d = soa_pkg::S_DIVD;
      soa_pkg::S_DIVD: begin
        if (op_q == soa_pkg::OP_FREE) begin
          state_d = free_pre_ok ? soa_pkg::S_FRD : soa_pkg::S_DONE;
        end else begin
          state_d = (head_q == soa_pkg::NIL_LINK) ? soa_pkg::S_FINDF : soa_pkg::S_WRD;
        end
      end
      soa_pkg::S_WRD:   state_d = soa_pkg::S_WCHK;
      soa_pkg::S_WCHK: begin
        if (free_bits != '0) state_d = soa_pkg::S_MUL;
        else if (!word_last) state_d = soa_pkg::S_WRD;
        else if (nx_rdata == soa_pkg::NIL_LINK) state_d = soa_pkg::S_FINDF;
        else state_d = soa_pkg::S_WRD;
      end
      soa_pkg::S_MUL:   state_d = soa_pkg::S_DONE;
      soa_pkg::S_FINDF: begin
        if (chunk_bits != 8'hFF) state_d = soa_pkg::S_INIT;
        else if (chunk_q == soa_pkg::CH_W'(soa_pkg::NCH - 1)) state_d = soa_pkg::S_DONE;
      end
      soa_pkg::S_INIT:  if (word_q == soa_pkg::WORD_W'(soa_pkg::WPS - 1)) state_d = soa_pkg::S_LINK;
      soa_pkg::S_LINK:  state_d = soa_pkg::S_DONE;
      soa_pkg::S_FRD:   state_d = soa_pkg::S_FCHK;
      soa_pkg::S_FCHK: begin
        if (!fbit_set || cnt_dec != '0) state_d = soa_pkg::S_DONE;
        else state_d = soa_pkg::S_UNL;
      end
      soa_pkg::S_UNL:   state_d = soa_pkg::S_DONE;
      soa_pkg::S_DONE:  if (out_free) state_d = soa_pkg::S_IDLE;
      default:          state_d = soa_pkg::S_IDLE;
    endcase
  end

  // ---- memory controls ----
  always_comb begin
    bm_we     = 1'b0;
    bm_waddr  = {cur_s, word_q};
    bm_wdata  = bm_rdata;
    bm_raddr  = {cur_s, word_q};
    cnt_we    = 1'b0;
    cnt_waddr = cur_s;
    cnt_wdata = cnt_rdata + 1'b1;
    cnt_raddr = cur_s;
    nx_we     = 1'b0;
    nx_waddr  = cur_s;
    nx_wdata  = soa_pkg::NIL_LINK;
    nx_raddr  = cur_s;
    pv_we     = 1'b0;
    pv_waddr  = cur_s;
    pv_wdata  = tail_q;
    pv_raddr  = cur_s;
    case (state_q)
      soa_pkg::S_WCHK: begin
        if (free_bits != '0) begin
          bm_we            = 1'b1;
          bm_wdata[free_bit] = 1'b1;
          cnt_we           = 1'b1;
        end
      end
      soa_pkg::S_INIT: begin
        bm_we    = 1'b1;
        bm_waddr = {new_q, word_q};
        bm_wdata = (word_q == '0) ? soa_pkg::BM_W'(1) : '0;
        if (word_q == '0) begin
          cnt_we    = 1'b1;
          cnt_waddr = new_q;
          cnt_wdata = soa_pkg::CNT_W'(1);
          nx_we     = 1'b1;
          nx_waddr  = new_q;
          pv_we     = 1'b1;
          pv_waddr  = new_q;
        end
      end
      soa_pkg::S_LINK: begin
        nx_we    = (tail_q != soa_pkg::NIL_LINK);
        nx_waddr = tail_q[soa_pkg::SLAB_W-1:0];
        nx_wdata = soa_pkg::LINK_W'(new_q);
      end
      soa_pkg::S_FRD: begin
        bm_raddr  = {sid_s, slot_q[soa_pkg::KW-1:soa_pkg::BIT_W]};
        cnt_raddr = sid_s;
        nx_raddr  = sid_s;
        pv_raddr  = sid_s;
      end
      soa_pkg::S_FCHK: begin
        if (fbit_set) begin
          bm_we        = 1'b1;
          bm_waddr     = {sid_s, slot_q[soa_pkg::KW-1:soa_pkg::BIT_W]};
          bm_wdata[fbit] = 1'b0;
          cnt_we       = 1'b1;
          cnt_waddr    = sid_s;
          cnt_wdata    = cnt_dec;
        end
      end
      soa_pkg::S_UNL: begin
        nx_we    = (p_q != soa_pkg::NIL_LINK);
        nx_waddr = p_q[soa_pkg::SLAB_W-1:0];
        nx_wdata = q_q;
        pv_we    = (q_q != soa_pkg::NIL_LINK);
        pv_waddr = q_q[soa_pkg::SLAB_W-1:0];
        pv_wdata = p_q;
      end
      default: ;
    endcase
  end

  // ---- control registers ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= soa_pkg::S_IDLE;
      obj_size_q <= soa_pkg::OBJ_RST;
      head_q     <= soa_pkg::NIL_LINK;
      tail_q     <= soa_pkg::NIL_LINK;
      act_q      <= '0;
      ov_q       <= 1'b0;
    end else begin
      state_q <= state_d;
      if (psel && penable && pwrite && paddr[2] == soa_pkg::REG_OBJ_SIZE) begin
        obj_size_q <= pwdata[soa_pkg::SZ_W-1:0];
      end
      if (rsp_o.ready) ov_q <= 1'b0;
      if (state_q == soa_pkg::S_DONE && out_free) ov_q <= 1'b1;
      case (state_q)
        soa_pkg::S_LINK: begin
          act_q[new_q] <= 1'b1;
          if (tail_q == soa_pkg::NIL_LINK) head_q <= soa_pkg::LINK_W'(new_q);
          tail_q <= soa_pkg::LINK_W'(new_q);
        end
        soa_pkg::S_FCHK: if (fbit_set && cnt_dec == '0) act_q[sid_s] <= 1'b0;
        soa_pkg::S_UNL: begin
          if (p_q == soa_pkg::NIL_LINK) head_q <= q_q;
          if (q_q == soa_pkg::NIL_LINK) tail_q <= p_q;
        end
        default: ;
      endcase
    end
  end

  // ---- datapath registers ----
  always_ff @(posedge clk_i) begin
    case (state_q)
      soa_pkg::S_IDLE: begin
        op_q    <= req_i.op;
        sid_q   <= req_i.slab_id;
        off_q   <= req_i.byte_offset;
        sz_q    <= eff_sz;
        quo_q   <= (req_i.op == soa_pkg::OP_FREE) ? soa_pkg::DIV_W'(req_i.byte_offset)
                                                   : soa_pkg::DIV_W'(soa_pkg::PAGE_BYTES);
        rem_q   <= '0;
        dcnt_q  <= soa_pkg::DCNT_W'(soa_pkg::DIV_W);
        word_q  <= '0;
        chunk_q <= '0;
      end
      soa_pkg::S_DIV: begin
        dcnt_q <= dcnt_q - 1'b1;
        quo_q  <= {quo_q[soa_pkg::DIV_W-2:0], div_ge};
        rem_q  <= div_ge ? rem_sh - (soa_pkg::DIV_W + 1)'(sz_q) : rem_sh;
      end
      soa_pkg::S_DIVD: begin
        n_q    <= n_w;
        cur_q  <= head_q;
        slot_q <= soa_pkg::KW'(quo_q);
        res_q  <= '{status: soa_pkg::ST_BAD_FREE, out_slab: '0, out_offset: '0,
                    slab_released: 1'b0};
      end
      soa_pkg::S_WCHK: begin
        if (free_bits != '0) begin
          slot_q <= {word_q, free_bit};
        end else if (!word_last) begin
          word_q <= word_q + 1'b1;
        end else begin
          word_q <= '0;
          cur_q  <= nx_rdata;
        end
      end
      soa_pkg::S_MUL: begin
        res_q.status        <= soa_pkg::ST_OK;
        res_q.out_slab      <= soa_pkg::SID_W'(cur_q);
        res_q.out_offset    <= soa_pkg::OFF_W'(slot_q * sz_q);
        res_q.slab_released <= 1'b0;
      end
      soa_pkg::S_FINDF: begin
        chunk_q <= chunk_q + 1'b1;
        new_q   <= find_slab;
        word_q  <= '0;
        res_q   <= '{status: soa_pkg::ST_NO_SLAB, out_slab: '0, out_offset: '0,
                     slab_released: 1'b0};
      end
      soa_pkg::S_INIT: word_q <= word_q + 1'b1;
      soa_pkg::S_LINK: begin
        res_q <= '{status: soa_pkg::ST_OK, out_slab: soa_pkg::SID_W'(new_q), out_offset: '0,
                   slab_released: 1'b0};
      end
      soa_pkg::S_FCHK: begin
        p_q <= pv_rdata;
        q_q <= nx_rdata;
        if (fbit_set) begin
          res_q <= '{status: soa_pkg::ST_OK, out_slab: sid_q, out_offset: off_q,
                     slab_released: 1'b0};
        end
      end
      soa_pkg::S_UNL: res_q.slab_released <= 1'b1;
      soa_pkg::S_DONE: if (out_free) out_q <= res_q;
      default: ;
    endcase
  end

  // ---- checks ----
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.status != soa_pkg::ST_OK) |->
      (rsp_o.out_slab == '0 && rsp_o.out_offset == '0 && !rsp_o.slab_released))
    else $error("error beat carries non-zero payload");

  a_rel_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.slab_released) |-> (rsp_o.status == soa_pkg::ST_OK))
    else $error("slab released on a failed request");

  a_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_q == soa_pkg::NIL_LINK) == (tail_q == soa_pkg::NIL_LINK))
    else $error("list head and tail disagree on emptiness");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> (state_q == soa_pkg::S_DIV))
    else $error("accepted request did not start the divider");

endmodule
